// ===== design/triangle_unit_normal_core_macros.svh =====
// Assertion macros shared by the triangle unit normal RTL.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TUN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TUN_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== design/tun_pkg.sv =====
// Shared constants and types of the triangle unit normal pipeline.
`default_nettype none

package tun_pkg;

  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;
  localparam int unsigned LANES             = 3;
  localparam int unsigned NORM_BITS         = 30;
  localparam int unsigned SQ_W              = 2 * NORM_BITS;
  localparam int unsigned SUM_W             = 2 * NORM_BITS + 2;
  localparam int unsigned ROOT_W            = NORM_BITS + 1;
  localparam int unsigned SQRT_REM_W        = ROOT_W + 3;
  localparam int unsigned DIV_W             = ROOT_W + 1;
  localparam int unsigned DIV_REM_W         = DIV_W + 1;

  typedef struct packed {
    logic             degen;
    logic [LANES-1:0] neg;
  } dv_side_t;

  typedef struct packed {
    dv_side_t                         tag;
    logic [LANES-1:0][NORM_BITS-1:0] mag;
  } sq_side_t;

endpackage

`default_nettype wire

// ===== design/triangle_unit_normal_core.sv =====
// Top level of the triangle unit normal pipeline.
// Throughput: one word per clock while the skid entry is empty; the square root takes one bit
//   per stage, the divider one quotient bit per stage, so both run at full rate.
// A two-entry output (register plus skid) lets input flow while a result waits.
// Reset clears the pipeline valid bits and the output and skid valid flags; payload is not reset.
`default_nettype none
`include "triangle_unit_normal_core_macros.svh"

module triangle_unit_normal_core
  import tun_pkg::*;
#(
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]     a_x_i,
  input  logic signed [COORD_WIDTH-1:0]     a_y_i,
  input  logic signed [COORD_WIDTH-1:0]     a_z_i,
  input  logic signed [COORD_WIDTH-1:0]     b_x_i,
  input  logic signed [COORD_WIDTH-1:0]     b_y_i,
  input  logic signed [COORD_WIDTH-1:0]     b_z_i,
  input  logic signed [COORD_WIDTH-1:0]     c_x_i,
  input  logic signed [COORD_WIDTH-1:0]     c_y_i,
  input  logic signed [COORD_WIDTH-1:0]     c_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [OUT_FRAC_BITS+1:0]   normal_x_o,
  output logic signed [OUT_FRAC_BITS+1:0]   normal_y_o,
  output logic signed [OUT_FRAC_BITS+1:0]   normal_z_o,
  output logic                              degenerate_o
);

  // Edge components keep at most NORM_BITS magnitude bits; wider coordinates
  // drop low bits of the edge magnitude.
  localparam int unsigned EW    = (COORD_WIDTH > NORM_BITS) ? NORM_BITS : COORD_WIDTH;
  localparam int unsigned ESH   = (COORD_WIDTH > NORM_BITS) ? COORD_WIDTH - NORM_BITS : 0;
  localparam int unsigned DW    = COORD_WIDTH + 1;
  localparam int unsigned PW    = 2 * EW + 2;
  localparam int unsigned MW    = 2 * EW + 1;
  localparam int unsigned BLW   = $clog2(MW + 1);
  localparam int unsigned QW    = OUT_FRAC_BITS + 1;
  localparam int unsigned OW    = OUT_FRAC_BITS + 2;
  localparam int unsigned FRONT = 8;
  localparam int unsigned NS    = FRONT + ROOT_W + QW;
  localparam logic signed [OW-1:0] Q_ONE  = OW'(2 ** OUT_FRAC_BITS);
  localparam logic signed [OW-1:0] Q_MONE = -Q_ONE;

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipeline advances unless the skid entry is full.
  // ---------------------------------------------------------------------------
  logic          en;
  logic [NS-1:0] vld_q;
  logic          sk_valid_q;
  logic          o_valid_q;

  assign en         = !sk_valid_q;
  assign in_stall_o = sk_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: edge vectors U = B - A, V = C - A.
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] a_v [LANES];
  logic signed [COORD_WIDTH-1:0] b_v [LANES];
  logic signed [COORD_WIDTH-1:0] c_v [LANES];
  logic signed [EW:0]            u_q [LANES];
  logic signed [EW:0]            v_q [LANES];

  assign a_v[0] = a_x_i;
  assign a_v[1] = a_y_i;
  assign a_v[2] = a_z_i;
  assign b_v[0] = b_x_i;
  assign b_v[1] = b_y_i;
  assign b_v[2] = b_z_i;
  assign c_v[0] = c_x_i;
  assign c_v[1] = c_y_i;
  assign c_v[2] = c_z_i;

  for (genvar l = 0; l < LANES; l++) begin : g_edge
    logic signed [DW-1:0] du;
    logic signed [DW-1:0] dv;
    logic [DW-1:0]        mu;
    logic [DW-1:0]        mv;
    logic [EW:0]          su;
    logic [EW:0]          sv;

    assign du = DW'(b_v[l]) - DW'(a_v[l]);
    assign dv = DW'(c_v[l]) - DW'(a_v[l]);
    assign mu = du[DW-1] ? DW'(-du) : DW'(du);
    assign mv = dv[DW-1] ? DW'(-dv) : DW'(dv);
    // truncate the magnitude toward zero, then reapply the sign
    assign su = {1'b0, EW'(mu >> ESH)};
    assign sv = {1'b0, EW'(mv >> ESH)};

    always_ff @(posedge clk_i) begin
      if (en) begin
        u_q[l] <= du[DW-1] ? -su : su;
        v_q[l] <= dv[DW-1] ? -sv : sv;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the six partial products of the cross product.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p_q [6];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= PW'(u_q[1]) * PW'(v_q[2]);
      p_q[1] <= PW'(u_q[2]) * PW'(v_q[1]);
      p_q[2] <= PW'(u_q[2]) * PW'(v_q[0]);
      p_q[3] <= PW'(u_q[0]) * PW'(v_q[2]);
      p_q[4] <= PW'(u_q[0]) * PW'(v_q[1]);
      p_q[5] <= PW'(u_q[1]) * PW'(v_q[0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: cross product N = U x V.
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] n_q [LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q[0] <= p_q[0] - p_q[1];
      n_q[1] <= p_q[2] - p_q[3];
      n_q[2] <= p_q[4] - p_q[5];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: split into sign and magnitude.
  // ---------------------------------------------------------------------------
  logic [MW-1:0]    mag3_q [LANES];
  logic [LANES-1:0] neg3_q;

  for (genvar l = 0; l < LANES; l++) begin : g_abs
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg3_q[l] <= n_q[l][PW-1];
        mag3_q[l] <= n_q[l][PW-1] ? MW'(-n_q[l]) : MW'(n_q[l]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: bit length of the largest magnitude (same as that of the OR).
  // ---------------------------------------------------------------------------
  logic [MW-1:0]    mag_or;
  logic [BLW-1:0]   bl_d;
  logic [MW-1:0]    mag4_q [LANES];
  logic [LANES-1:0] neg4_q;
  logic [BLW-1:0]   bl4_q;
  logic             degen4_q;

  assign mag_or = mag3_q[0] | mag3_q[1] | mag3_q[2];

  always_comb begin
    bl_d = '0;
    for (int i = 0; i < MW; i++) begin
      if (mag_or[i]) begin
        bl_d = BLW'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      bl4_q    <= bl_d;
      degen4_q <= (mag_or == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: block normalize so the largest magnitude has NORM_BITS bits.
  // mag * 2^NORM_BITS >> bl covers both the exact left shift and the
  // truncating right shift.
  // ---------------------------------------------------------------------------
  logic [NORM_BITS-1:0] nm5_q [LANES];
  logic [LANES-1:0]     neg5_q;
  logic                 degen5_q;

  for (genvar l = 0; l < LANES; l++) begin : g_norm
    logic [MW+NORM_BITS-1:0] wide;

    assign wide = {mag4_q[l], {NORM_BITS{1'b0}}} >> bl4_q;

    always_ff @(posedge clk_i) begin
      if (en) begin
        nm5_q[l] <= wide[NORM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg5_q   <= neg4_q;
      degen5_q <= degen4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: squares.  Stage 7: sum of squares.
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]      sq6_q [LANES];
  logic [NORM_BITS-1:0] nm6_q [LANES];
  logic [LANES-1:0]     neg6_q;
  logic                 degen6_q;
  logic [SUM_W-1:0]     sum7_q;
  sq_side_t             side7_q;

  for (genvar l = 0; l < LANES; l++) begin : g_sq
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq6_q[l] <= SQ_W'(nm5_q[l]) * SQ_W'(nm5_q[l]);
        nm6_q[l] <= nm5_q[l];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg6_q              <= neg5_q;
      degen6_q            <= degen5_q;
      sum7_q              <= SUM_W'(sq6_q[0]) + SUM_W'(sq6_q[1]) + SUM_W'(sq6_q[2]);
      side7_q.tag.degen   <= degen6_q;
      side7_q.tag.neg     <= neg6_q;
      side7_q.mag[0]      <= nm6_q[0];
      side7_q.mag[1]      <= nm6_q[1];
      side7_q.mag[2]      <= nm6_q[2];
    end
  end

  // ---------------------------------------------------------------------------
  // Length L = floor(sqrt(sum)), then n = floor((mag * 2^QW + L) / 2L).
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0]         root;
  sq_side_t                  sq_side;
  logic [LANES-1:0][QW-1:0]  quo;
  dv_side_t                  dv_side;

  tun_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum7_q),
    .side_i (side7_q),
    .root_o (root),
    .side_o (sq_side)
  );

  tun_div #(
    .QW (QW)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .mag_i  (sq_side.mag),
    .root_i (root),
    .side_i (sq_side.tag),
    .quo_o  (quo),
    .side_o (dv_side)
  );

  // ---------------------------------------------------------------------------
  // Apply signs; force zero on a degenerate triangle (the divider saw L = 0).
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][OW-1:0] word_norm;

  for (genvar l = 0; l < LANES; l++) begin : g_sign
    assign word_norm[l] = dv_side.degen  ? '0 :
                          dv_side.neg[l] ? -OW'(quo[l]) : OW'(quo[l]);
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry behind it.
  // ---------------------------------------------------------------------------
  logic [LANES-1:0][OW-1:0] o_norm_q;
  logic                     o_degen_q;
  logic [LANES-1:0][OW-1:0] sk_norm_q;
  logic                     sk_degen_q;
  logic                     pipe_valid;

  assign pipe_valid = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (!o_valid_q || !out_stall_i) begin
      // drain the skid entry first; the pipeline is held while it is full
      if (sk_valid_q) begin
        o_valid_q  <= 1'b1;
        sk_valid_q <= 1'b0;
      end else begin
        o_valid_q  <= pipe_valid;
      end
    end else if (pipe_valid && en) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!o_valid_q || !out_stall_i) begin
      if (sk_valid_q) begin
        o_norm_q  <= sk_norm_q;
        o_degen_q <= sk_degen_q;
      end else begin
        o_norm_q  <= word_norm;
        o_degen_q <= dv_side.degen;
      end
    end else if (pipe_valid && en) begin
      sk_norm_q  <= word_norm;
      sk_degen_q <= dv_side.degen;
    end
  end

  assign out_valid_o  = o_valid_q;
  assign normal_x_o   = o_norm_q[0];
  assign normal_y_o   = o_norm_q[1];
  assign normal_z_o   = o_norm_q[2];
  assign degenerate_o = o_degen_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TUN_ASSERT_NEVER(a_skid_without_out, sk_valid_q && !o_valid_q, "skid full, output empty")
  `TUN_ASSERT(a_skid_on_stall, $rose(sk_valid_q) |-> $past(out_stall_i),
              "skid filled without a stall")
  `TUN_ASSERT(a_degen_zero, out_valid_o && degenerate_o |->
              normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0,
              "degenerate word with nonzero normal")
  `TUN_ASSERT(a_norm_range, out_valid_o && !degenerate_o |->
              normal_x_o <= Q_ONE && normal_x_o >= Q_MONE &&
              normal_y_o <= Q_ONE && normal_y_o >= Q_MONE &&
              normal_z_o <= Q_ONE && normal_z_o >= Q_MONE,
              "normal component out of range")

endmodule

`default_nettype wire

// ===== design/tun_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module tun_sqrt
  import tun_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SUM_W-1:0]  rad_i,
  input  sq_side_t          side_i,
  output logic [ROOT_W-1:0] root_o,
  output sq_side_t          side_o
);

  logic [SUM_W-1:0]      rad_q  [ROOT_W];
  logic [SQRT_REM_W-1:0] rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];
  sq_side_t              side_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_step
    logic [SUM_W-1:0]      rad_p;
    logic [SQRT_REM_W-1:0] rem_p;
    logic [SQRT_REM_W-1:0] rem_s;
    logic [SQRT_REM_W-1:0] trial;
    logic [ROOT_W-1:0]     root_p;
    sq_side_t              side_p;

    if (j == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign rad_p  = rad_q[j-1];
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign side_p = side_q[j-1];
    end

    // bring down the next pair of radicand bits, try root*4+1
    assign rem_s = {rem_p[SQRT_REM_W-3:0], rad_p[2*(ROOT_W-1-j) +: 2]};
    assign trial = {1'b0, root_p, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= rad_p;
        side_q[j] <= side_p;
        if (rem_s >= trial) begin
          rem_q[j]  <= rem_s - trial;
          root_q[j] <= {root_p[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_s;
          root_q[j] <= {root_p[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];
  assign side_o = side_q[ROOT_W-1];

endmodule

`default_nettype wire

// ===== design/tun_div.sv =====
// Pipelined rounding divider, three lanes sharing one divisor.
`default_nettype none

module tun_div
  import tun_pkg::*;
#(
  parameter int unsigned QW = OUT_FRAC_BITS_DEF + 1
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [LANES-1:0][NORM_BITS-1:0] mag_i,
  input  logic [ROOT_W-1:0]                root_i,
  input  dv_side_t                         side_i,
  output logic [LANES-1:0][QW-1:0]         quo_o,
  output dv_side_t                         side_o
);

  // numerator is mag * 2^QW + root; its low QW bits are the low bits of root
  logic [ROOT_W+QW-1:0]              root_ext;
  logic [LANES-1:0][DIV_REM_W-1:0]   hi0;
  logic [DIV_W-1:0]                  d0;

  assign root_ext = {{QW{1'b0}}, root_i};
  assign d0       = {root_i, 1'b0};

  for (genvar l = 0; l < LANES; l++) begin : g_hi
    assign hi0[l] = DIV_REM_W'(mag_i[l]) + DIV_REM_W'(root_i >> QW);
  end

  logic [LANES-1:0][DIV_REM_W-1:0] rem_q  [QW];
  logic [LANES-1:0][QW-1:0]        quo_q  [QW];
  logic [QW-1:0]                   lo_q   [QW];
  logic [DIV_W-1:0]                d_q    [QW];
  dv_side_t                        side_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [LANES-1:0][DIV_REM_W-1:0] rem_p;
    logic [LANES-1:0][QW-1:0]        quo_p;
    logic [QW-1:0]                   lo_p;
    logic [DIV_W-1:0]                d_p;
    dv_side_t                        side_p;

    if (i == 0) begin : g_first
      assign rem_p  = hi0;
      assign quo_p  = '0;
      assign lo_p   = root_ext[QW-1:0];
      assign d_p    = d0;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[i-1];
      assign quo_p  = quo_q[i-1];
      assign lo_p   = lo_q[i-1];
      assign d_p    = d_q[i-1];
      assign side_p = side_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[i]   <= lo_p;
        d_q[i]    <= d_p;
        side_q[i] <= side_p;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DIV_REM_W-1:0] rem_s;

      assign rem_s = {rem_p[l][DIV_REM_W-2:0], lo_p[QW-1-i]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (rem_s >= {1'b0, d_p}) begin
            rem_q[i][l] <= rem_s - {1'b0, d_p};
            quo_q[i][l] <= {quo_p[l][QW-2:0], 1'b1};
          end else begin
            rem_q[i][l] <= rem_s;
            quo_q[i][l] <= {quo_p[l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign quo_o  = quo_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

// ===== sim/triangle_unit_normal_core_tb.sv =====
// Self-checking testbench for the triangle unit normal pipeline.
`default_nettype none

module triangle_unit_normal_core_tb
  import tun_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW  = COORD_WIDTH_DEF;
  localparam int unsigned OFB = OUT_FRAC_BITS_DEF;
  localparam int unsigned OW  = OFB + 2;
  localparam int unsigned LATENCY = 8 + 31 + (OFB + 1) + 1;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [OW-1:0] nx, ny, nz;
    logic                 degen;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [CW-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic signed [CW-1:0] c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [OW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;

  normal_t expected_normals[$];
  int  errors = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  degen_seen = 0;
  longint cycles = 0;
  // Receiver stall pattern: 0 = never, 1 = light, 2 = heavy.
  int  stall_mode = 1;

  triangle_unit_normal_core i_dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Integer square root, floor.
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Compute the rounded unit normal of triangle a, b, c.
  function automatic normal_t unit_normal(logic signed [CW-1:0] v[9]);
    longint          u[3], w[3], n[3];
    longint unsigned mag[3], maxmag, sum, len, q;
    logic            neg[3];
    int              bl;
    normal_t         r;
    maxmag = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'(v[3+i]) - longint'(v[i]);
      w[i] = longint'(v[6+i]) - longint'(v[i]);
    end
    n[0] = u[1]*w[2] - u[2]*w[1];
    n[1] = u[2]*w[0] - u[0]*w[2];
    n[2] = u[0]*w[1] - u[1]*w[0];
    for (int i = 0; i < 3; i++) begin
      neg[i] = n[i] < 0;
      mag[i] = neg[i] ? -n[i] : n[i];
      if (mag[i] > maxmag) maxmag = mag[i];
    end
    if (maxmag == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
      return r;
    end
    bl = 0;
    while ((maxmag >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > NORM_BITS) mag[i] >>= (bl - NORM_BITS);
      else mag[i] <<= (NORM_BITS - bl);
      sum += mag[i] * mag[i];
    end
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (OFB + 1)) + len) / (2 * len);
      n[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    r.nx = n[0][OW-1:0];
    r.ny = n[1][OW-1:0];
    r.nz = n[2][OW-1:0];
    r.degen = 1'b0;
    return r;
  endfunction

  // Send one word and queue its expected normal at acceptance.
  task automatic send_word(logic signed [CW-1:0] v[9]);
    a_x_i <= v[0]; a_y_i <= v[1]; a_z_i <= v[2];
    b_x_i <= v[3]; b_y_i <= v[4]; b_z_i <= v[5];
    c_x_i <= v[6]; c_y_i <= v[7]; c_z_i <= v[8];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_normals.push_back(unit_normal(v));
    words_sent++;
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every expected normal has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_normals.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return CW'($urandom_range(0, 7)) - CW'(3);
      default: return CW'($urandom);
    endcase
  endfunction

  // Checker: compare each accepted word with the oldest expectation.
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (stall_mode == 0) out_stall_i <= 1'b0;
      else if (stall_mode == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
      else out_stall_i <= ($urandom_range(0, 3) != 0);
      if (out_valid_o && !out_stall_i) begin
        if (expected_normals.size() == 0) begin
          $display("%0t: unexpected word nx=%0d ny=%0d nz=%0d degen=%0b", $realtime,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          errors++;
        end else begin
          e = expected_normals.pop_front();
          words_checked++;
          if (e.degen) degen_seen++;
          if (normal_x_o !== e.nx) begin
            $display("%0t: normal_x expected %0d actual %0d", $realtime, e.nx, normal_x_o);
            errors++;
          end
          if (normal_y_o !== e.ny) begin
            $display("%0t: normal_y expected %0d actual %0d", $realtime, e.ny, normal_y_o);
            errors++;
          end
          if (normal_z_o !== e.nz) begin
            $display("%0t: normal_z expected %0d actual %0d", $realtime, e.nz, normal_z_o);
            errors++;
          end
          if (degenerate_o !== e.degen) begin
            $display("%0t: degenerate expected %0b actual %0b", $realtime, e.degen,
                     degenerate_o);
            errors++;
          end
        end
      end
    end
  end

  // Abort on a hung pipeline.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Axis-aligned, extreme and degenerate triangles.
  task automatic test_directed();
    logic signed [CW-1:0] v[9];
    // Right triangles on each axis plane, both windings on the xy plane.
    v = '{0,0,0, 4096,0,0, 0,4096,0};        send_word(v);
    v = '{0,0,0, 0,4096,0, 4096,0,0};        send_word(v);
    v = '{0,0,0, 0,4096,0, 0,0,4096};        send_word(v);
    v = '{0,0,0, 0,0,4096, 4096,0,0};        send_word(v);
    // Coincident and collinear vertices.
    v = '{100,200,300, 100,200,300, 100,200,300}; send_word(v);
    v = '{0,0,0, 1,1,1, 2,2,2};              send_word(v);
    v = '{-32768,-32768,-32768, 32767,32767,32767, 32767,32767,32767}; send_word(v);
    // Full-range edges stress the widest cross product.
    v = '{-32768,-32768,-32768, 32767,-32768,-32768, -32768,32767,-32768}; send_word(v);
    v = '{32767,32767,32767, -32768,32767,32767, 32767,32767,-32768}; send_word(v);
    v = '{-32768,32767,-32768, 32767,-32768,32767, 32767,32767,-32768}; send_word(v);
    // Tiny triangles: smallest nonzero cross product.
    v = '{0,0,0, 1,0,0, 0,1,0};              send_word(v);
    v = '{-1,-1,-1, 0,-1,-1, -1,-1,0};       send_word(v);
    // Diagonal normal hits rounding of 1/sqrt(3).
    v = '{4096,0,0, 0,4096,0, 0,0,4096};     send_word(v);
    v = '{-4096,0,0, 0,-4096,0, 0,0,-4096};  send_word(v);
    drain();
  endtask

  // Random triangles in bursts with gaps, mixing degenerate ones in.
  task automatic test_random(int count, int mode);
    logic signed [CW-1:0] v[9];
    int burst;
    stall_mode = mode;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        for (int i = 0; i < 9; i++) v[i] = rand_coord();
        // Force a degenerate case now and then.
        if ($urandom_range(0, 15) == 0)
          for (int i = 0; i < 3; i++) v[3+i] = v[i];
        send_word(v);
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 1);
    test_random(450, 2);
    test_random(500, 0);
    // Let the pipeline settle and catch any stray word.
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("Sent %0d triangles, checked %0d normals (%0d degenerate), %0d errors.",
             words_sent, words_checked, degen_seen, errors);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
